/* design/pmdsw_pkg.sv */
// Package: shared types, constants and helpers for the page-mode shadow writer.
package pmdsw_pkg;

	localparam int COLUMNS     = 128;
	localparam int PAGES       = 8;
	localparam int FRAME_BYTES = COLUMNS * PAGES;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);
	localparam int COL_W       = 7;
	localparam int PAGE_W      = 3;
	localparam int ROW_W       = 6;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	// input mode codes
	localparam logic [1:0] MODE_PIXEL    = 2'd0;
	localparam logic [1:0] MODE_POSITION = 2'd1;
	localparam logic [1:0] MODE_DATA     = 2'd2;

	// controller bytes
	localparam logic [7:0] CTRL_CMD    = 8'h00;
	localparam logic [7:0] CTRL_DATA   = 8'h40;
	localparam logic [7:0] CMD_PAGE    = 8'hB0;
	localparam logic [7:0] CMD_COL_HI  = 8'h10;
	localparam logic [7:0] COL_LO_MASK = 8'h0F;

	// byte positions within the emitted sequence
	localparam logic [2:0] STEP_CMD    = 3'd0;
	localparam logic [2:0] STEP_PAGE   = 3'd1;
	localparam logic [2:0] STEP_COL_LO = 3'd2;
	localparam logic [2:0] STEP_COL_HI = 3'd3;
	localparam logic [2:0] STEP_DCTRL  = 3'd4;
	localparam logic [2:0] STEP_DBYTE  = 3'd5;

	typedef enum logic [1:0] {
		OP_PIXEL,
		OP_POSITION,
		OP_DATA
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MODIFY,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] pixel_row;
		logic [PAGE_W-1:0] page;
		logic             color;
		logic [7:0]       data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       byte_valid;
		logic       transfer_start;
		logic       transfer_end;
		logic       status;
		logic       last;
	} out_item_t;

	typedef struct packed {
		op_t               op;
		logic [COL_W-1:0]  column;
		logic [PAGE_W-1:0] page;
		logic [2:0]        bit_sel;
		logic              color;
		logic [7:0]        data_byte;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] frame_addr(input logic [PAGE_W-1:0] pg,
			input logic [COL_W-1:0] col);
		frame_addr = ADDR_W'(pg) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

	function automatic logic [COL_W-1:0] next_col(input logic [COL_W-1:0] col);
		if (col == COL_W'(COLUMNS - 1)) begin
			next_col = '0;
		end else begin
			next_col = col + COL_W'(1);
		end
	endfunction

endpackage

/* design/pmdsw_ram.sv */
// Generic single-port RAM with registered read.
module pmdsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* design/pmdsw_front.sv */
// Front end: accepts input items, drops ignored ones, turns the rest into commands.
module pmdsw_front (
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  pmdsw_pkg::in_item_t cmd,
	input  logic                q_full,
	input  logic                clearing,
	output logic                push,
	output pmdsw_pkg::cmd_t     push_cmd
);

	logic [pmdsw_pkg::PAGE_W-1:0] pix_page;
	logic                         col_ok;
	logic                         keep;

	assign cmd_ready = !q_full && !clearing;
	assign pix_page  = cmd.pixel_row[pmdsw_pkg::ROW_W-1:3];
	assign col_ok    = int'(cmd.column) < pmdsw_pkg::COLUMNS;

	always_comb begin
		push_cmd           = '0;
		push_cmd.column    = cmd.column;
		push_cmd.bit_sel   = cmd.pixel_row[2:0];
		push_cmd.color     = cmd.color;
		push_cmd.data_byte = cmd.data_byte;
		keep               = 1'b0;
		case (cmd.mode)
			pmdsw_pkg::MODE_PIXEL: begin
				push_cmd.op   = pmdsw_pkg::OP_PIXEL;
				push_cmd.page = pix_page;
				keep          = col_ok && (int'(pix_page) < pmdsw_pkg::PAGES);
			end
			pmdsw_pkg::MODE_POSITION: begin
				push_cmd.op   = pmdsw_pkg::OP_POSITION;
				push_cmd.page = cmd.page;
				keep          = col_ok && (int'(cmd.page) < pmdsw_pkg::PAGES);
			end
			pmdsw_pkg::MODE_DATA: begin
				push_cmd.op   = pmdsw_pkg::OP_DATA;
				push_cmd.page = cmd.page;
				keep          = 1'b1;
			end
			default: begin
				// unused mode: swallowed
				push_cmd.op = pmdsw_pkg::OP_DATA;
				keep        = 1'b0;
			end
		endcase
		push = cmd_valid && cmd_ready && keep;
	end

endmodule

/* design/pmdsw_queue.sv */
// Short command queue between front and back end.
module pmdsw_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pmdsw_pkg::cmd_t push_cmd,
	input  logic            pop,
	output pmdsw_pkg::cmd_t head,
	output logic            empty,
	output logic            full
);

	pmdsw_pkg::cmd_t                entry_q [pmdsw_pkg::QDEPTH];
	logic [pmdsw_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [pmdsw_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [pmdsw_pkg::QCNT_W-1:0]   count_q;

	assign empty = count_q == '0;
	assign full  = count_q == pmdsw_pkg::QCNT_W'(pmdsw_pkg::QDEPTH);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + pmdsw_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + pmdsw_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + pmdsw_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - pmdsw_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* design/pmdsw_back.sv */
// Back end: shadow frame read-modify-write, cursor and bus byte sequencer.
module pmdsw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pmdsw_pkg::cmd_t      head,
	input  logic                 empty,
	output logic                 pop,
	output logic                 clearing,
	output logic                 bus_valid,
	input  logic                 bus_ready,
	output pmdsw_pkg::out_item_t bus
);

	pmdsw_pkg::state_t             state_q, state_d;
	pmdsw_pkg::cmd_t               cmd_q;
	logic [2:0]                    step_q, step_d;
	logic                          stat_q, stat_d;
	logic [7:0]                    data_q, data_d;
	logic [pmdsw_pkg::COL_W-1:0]   cur_col_q, cur_col_d;
	logic [pmdsw_pkg::PAGE_W-1:0]  cur_page_q, cur_page_d;
	logic [pmdsw_pkg::ADDR_W-1:0]  clr_q;
	logic                          out_valid_q;
	pmdsw_pkg::out_item_t          out_q;

	logic                          ram_we;
	logic [pmdsw_pkg::ADDR_W-1:0]  ram_addr;
	logic [7:0]                    ram_wdata;
	logic [7:0]                    ram_rdata;
	logic [7:0]                    mask;
	logic [7:0]                    new_byte;
	logic [2:0]                    end_step;
	logic                          out_free;
	logic                          load;
	logic                          take_cmd;
	pmdsw_pkg::out_item_t          item;

	pmdsw_ram #(
		.WIDTH(8),
		.DEPTH(pmdsw_pkg::FRAME_BYTES)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign clearing  = state_q == pmdsw_pkg::ST_CLEAR;
	assign out_free  = !out_valid_q || bus_ready;
	assign mask      = 8'(1) << cmd_q.bit_sel;
	assign new_byte  = cmd_q.color ? (ram_rdata | mask) : (ram_rdata & ~mask);
	assign end_step  = (cmd_q.op == pmdsw_pkg::OP_POSITION) ? pmdsw_pkg::STEP_COL_HI
	                                                        : pmdsw_pkg::STEP_DBYTE;
	assign bus_valid = out_valid_q;
	assign bus       = out_q;

	// byte for the current step
	always_comb begin
		item            = '0;
		item.byte_valid = !stat_q;
		item.status     = stat_q;
		item.last       = stat_q || (step_q == end_step);
		if (!stat_q) begin
			item.transfer_start = (step_q == pmdsw_pkg::STEP_CMD) ||
			                      (step_q == pmdsw_pkg::STEP_DCTRL);
			item.transfer_end   = (step_q == pmdsw_pkg::STEP_COL_HI) ||
			                      (step_q == pmdsw_pkg::STEP_DBYTE);
			case (step_q)
				pmdsw_pkg::STEP_CMD:    item.bus_byte = pmdsw_pkg::CTRL_CMD;
				pmdsw_pkg::STEP_PAGE:   item.bus_byte = pmdsw_pkg::CMD_PAGE | 8'(cmd_q.page);
				pmdsw_pkg::STEP_COL_LO: item.bus_byte = 8'(cmd_q.column) & pmdsw_pkg::COL_LO_MASK;
				pmdsw_pkg::STEP_COL_HI: item.bus_byte = pmdsw_pkg::CMD_COL_HI |
				                                        8'(cmd_q.column >> 4);
				pmdsw_pkg::STEP_DCTRL:  item.bus_byte = pmdsw_pkg::CTRL_DATA;
				pmdsw_pkg::STEP_DBYTE:  item.bus_byte = data_q;
				default:                item.bus_byte = '0;
			endcase
		end
	end

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		stat_d     = stat_q;
		data_d     = data_q;
		cur_col_d  = cur_col_q;
		cur_page_d = cur_page_q;
		ram_we     = 1'b0;
		ram_addr   = pmdsw_pkg::frame_addr(head.page, head.column);
		ram_wdata  = '0;
		pop        = 1'b0;
		take_cmd   = 1'b0;
		load       = 1'b0;
		case (state_q)
			pmdsw_pkg::ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
				if (clr_q == pmdsw_pkg::ADDR_W'(pmdsw_pkg::FRAME_BYTES - 1)) begin
					state_d = pmdsw_pkg::ST_IDLE;
				end
			end
			pmdsw_pkg::ST_IDLE: begin
				if (!empty) begin
					pop      = 1'b1;
					take_cmd = 1'b1;
					stat_d   = 1'b0;
					case (head.op)
						pmdsw_pkg::OP_PIXEL: begin
							// read issued now, byte arrives next cycle
							state_d = pmdsw_pkg::ST_MODIFY;
						end
						pmdsw_pkg::OP_POSITION: begin
							cur_col_d  = head.column;
							cur_page_d = head.page;
							step_d     = pmdsw_pkg::STEP_CMD;
							state_d    = pmdsw_pkg::ST_EMIT;
						end
						default: begin
							ram_we    = 1'b1;
							ram_addr  = pmdsw_pkg::frame_addr(cur_page_q, cur_col_q);
							ram_wdata = head.data_byte;
							data_d    = head.data_byte;
							cur_col_d = pmdsw_pkg::next_col(cur_col_q);
							step_d    = pmdsw_pkg::STEP_DCTRL;
							state_d   = pmdsw_pkg::ST_EMIT;
						end
					endcase
				end
			end
			pmdsw_pkg::ST_MODIFY: begin
				ram_addr = pmdsw_pkg::frame_addr(cmd_q.page, cmd_q.column);
				state_d  = pmdsw_pkg::ST_EMIT;
				if (new_byte == ram_rdata) begin
					stat_d = 1'b1;
				end else begin
					ram_we     = 1'b1;
					ram_wdata  = new_byte;
					data_d     = new_byte;
					cur_page_d = cmd_q.page;
					cur_col_d  = pmdsw_pkg::next_col(cmd_q.column);
					step_d     = pmdsw_pkg::STEP_CMD;
				end
			end
			pmdsw_pkg::ST_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					if (stat_q || step_q == end_step) begin
						state_d = pmdsw_pkg::ST_IDLE;
					end else begin
						step_d = step_q + 3'd1;
					end
				end
			end
			default: state_d = pmdsw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pmdsw_pkg::ST_CLEAR;
			clr_q       <= '0;
			cur_col_q   <= '0;
			cur_page_q  <= '0;
			out_valid_q <= 1'b0;
			step_q      <= pmdsw_pkg::STEP_CMD;
			stat_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			cur_col_q  <= cur_col_d;
			cur_page_q <= cur_page_d;
			step_q     <= step_d;
			stat_q     <= stat_d;
			if (state_q == pmdsw_pkg::ST_CLEAR) begin
				clr_q <= clr_q + pmdsw_pkg::ADDR_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (bus_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
		if (take_cmd) begin
			cmd_q <= head;
		end
		if (load) begin
			out_q <= item;
		end
	end

endmodule

/* design/page_mode_display_shadow_writer_core.sv */
// Top level: page-mode shadow writer, front end, command queue and back end.
//
// Takes drawing items on the cmd channel (set_pixel, set_position, write_data)
// and gives one bus item per controller byte on the bus channel, both with
// valid/ready. A set_pixel that changes the shadow byte gives a four-byte
// position transfer and a two-byte data transfer; an unchanged pixel gives a
// single status item. set_position gives four bytes, write_data two. Unused
// mode and out-of-range positions are swallowed with no result.
// The front end accepts an item while the queue (two entries) has room.
// The back end serialises: a set_pixel is popped, then goes through a shadow
// read-modify-write through the single RAM port and six bus bytes; set_position
// and write_data are popped and then give their bytes. The sequencer loads one
// bus byte a cycle while the receiver is ready, and pops the next command only
// after the last item of the current one has been loaded.
// After reset the shadow frame, all 1024 bytes, is cleared one byte a cycle,
// during which cmd_ready stays low. The bus side holds its item in an output
// register; while the receiver stalls the sequencer waits and the front end
// keeps filling the queue until it is full.
module page_mode_display_shadow_writer_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  pmdsw_pkg::in_item_t  cmd,
	output logic                 bus_valid,
	input  logic                 bus_ready,
	output pmdsw_pkg::out_item_t bus
);

	logic            push;
	pmdsw_pkg::cmd_t push_cmd;
	pmdsw_pkg::cmd_t head;
	logic            pop;
	logic            q_empty;
	logic            q_full;
	logic            clearing;

	pmdsw_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_full    (q_full),
		.clearing  (clearing),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	pmdsw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	pmdsw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.clearing  (clearing),
		.bus_valid (bus_valid),
		.bus_ready (bus_ready),
		.bus       (bus)
	);

endmodule

/* tb/bus_byte_checker.sv */
// Bus byte checker: shadow-frame predictor and in-order comparison of bus items.
module bus_byte_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic                 cmd_ready,
	input  pmdsw_pkg::in_item_t  cmd,
	input  logic                 bus_valid,
	input  logic                 bus_ready,
	input  pmdsw_pkg::out_item_t bus,
	output int                   mismatches,
	output int                   bytes_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	import pmdsw_pkg::*;

	// cap on printed lines; every mismatch is still counted
	localparam int SHOWN_MAX = 40;

	logic [7:0]        shadow [FRAME_BYTES];
	logic [COL_W-1:0]  cur_col;
	logic [PAGE_W-1:0] cur_page;
	out_item_t         owed [$];
	int                fails = 0;
	int                owed_count = 0;

	assign mismatches = fails;
	assign bytes_owed = owed_count;

	task automatic report(input string msg);
		if (fails < SHOWN_MAX) begin
			$display("%0t ns: bus mismatch: %s", $time, msg);
		end
		fails++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want) begin
			report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
		end
	endtask

	function automatic void owe(input logic [7:0] b, input logic start, input logic xfer_end,
			input logic stat, input logic fin);
		out_item_t e;
		e.bus_byte       = b;
		e.byte_valid     = ~stat;
		e.transfer_start = start;
		e.transfer_end   = xfer_end;
		e.status         = stat;
		e.last           = fin;
		owed.push_back(e);
	endfunction

	function automatic void owe_position(input logic [PAGE_W-1:0] pg,
			input logic [COL_W-1:0] col, input logic fin);
		owe(CTRL_CMD, 1'b1, 1'b0, 1'b0, 1'b0);
		owe(CMD_PAGE | 8'(pg), 1'b0, 1'b0, 1'b0, 1'b0);
		owe(8'(col) & COL_LO_MASK, 1'b0, 1'b0, 1'b0, 1'b0);
		owe(CMD_COL_HI | 8'(col >> 4), 1'b0, 1'b1, 1'b0, fin);
	endfunction

	// store at the cursor, send the data transfer, step the column within its page
	function automatic void owe_data(input logic [7:0] b);
		int idx;
		idx = (int'(cur_page) * COLUMNS + int'(cur_col)) % FRAME_BYTES;
		shadow[idx] = b;
		owe(CTRL_DATA, 1'b1, 1'b0, 1'b0, 1'b0);
		owe(b, 1'b0, 1'b1, 1'b0, 1'b1);
		cur_col = (int'(cur_col) == COLUMNS - 1) ? '0 : cur_col + 1'b1;
	endfunction

	function automatic void predict_drawing(input in_item_t it);
		logic [PAGE_W-1:0] pg;
		int                idx;
		logic [7:0]        was;
		logic [7:0]        updated;
		case (it.mode)
		MODE_PIXEL: begin
			pg = it.pixel_row[ROW_W-1:3];
			if (int'(it.column) >= COLUMNS || int'(pg) >= PAGES) return;
			idx = (int'(pg) * COLUMNS + int'(it.column)) % FRAME_BYTES;
			was = shadow[idx];
			updated = was;
			updated[it.pixel_row[2:0]] = it.color;
			if (updated == was) begin
				owe(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
			end else begin
				owe_position(pg, it.column, 1'b0);
				cur_page = pg;
				cur_col  = it.column;
				owe_data(updated);
			end
		end
		MODE_POSITION: begin
			if (int'(it.column) >= COLUMNS || int'(it.page) >= PAGES) return;
			owe_position(it.page, it.column, 1'b1);
			cur_page = it.page;
			cur_col  = it.column;
		end
		MODE_DATA: begin
			owe_data(it.data_byte);
		end
		default: begin
		end
		endcase
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			foreach (shadow[i]) shadow[i] = '0;
			cur_col  = '0;
			cur_page = '0;
			owed.delete();
		end else begin
			// results pass through the queue and the output register after their item, so check first
			if (bus_valid && bus_ready) begin
				if (owed.size() == 0) begin
					report($sformatf("item 0x%0h with nothing expected", bus));
				end else begin
					want = owed.pop_front();
					compare_field("bus_byte", bus.bus_byte, want.bus_byte);
					compare_field("byte_valid", bus.byte_valid, want.byte_valid);
					compare_field("transfer_start", bus.transfer_start, want.transfer_start);
					compare_field("transfer_end", bus.transfer_end, want.transfer_end);
					compare_field("status", bus.status, want.status);
					compare_field("last", bus.last, want.last);
				end
			end
			if (cmd_valid && cmd_ready) begin
				predict_drawing(cmd);
			end
		end
		owed_count = owed.size();
	end

endmodule

/* tb/tb_page_mode_display_shadow_writer_core.sv */
// Testbench top: clock, reset, drawing stimulus, bus back-pressure and verdict.
module tb_page_mode_display_shadow_writer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import pmdsw_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 320;
	localparam int HOLD_CYCLES  = 80;
	localparam int TAIL_CYCLES  = 16;
	localparam int LIMIT_NS     = 400_000;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_PATTERN,
		RX_STARVED
	} rx_style_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	in_item_t  cmd = '0;
	logic      bus_valid;
	logic      bus_ready = 1'b0;
	out_item_t bus;
	int        mismatches;
	int        bytes_owed;

	bit        sender_idles = 1'b0;
	int        burst_max = 0;
	int        gap_max = 1;
	int        burst_left = 0;
	rx_style_t rx_style = RX_FREE;
	bit        hold_req = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	page_mode_display_shadow_writer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.bus_valid (bus_valid),
		.bus_ready (bus_ready),
		.bus       (bus)
	);

	bus_byte_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.bus_valid  (bus_valid),
		.bus_ready  (bus_ready),
		.bus        (bus),
		.mismatches (mismatches),
		.bytes_owed (bytes_owed)
	);

	function automatic in_item_t drawing(input logic [1:0] mode, input int col, input int row,
			input int pg, input logic colr, input logic [7:0] dbyte);
		in_item_t it;
		it.mode      = mode;
		it.column    = COL_W'(col);
		it.pixel_row = ROW_W'(row);
		it.page      = PAGE_W'(pg);
		it.color     = colr;
		it.data_byte = dbyte;
		return it;
	endfunction

	// entered at a falling edge, leaves at a falling edge
	task automatic send_item(input in_item_t it, input bit hold_after);
		cmd       <= it;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		if (hold_after) hold_req = 1'b1;
		@(negedge clk);
		if (!sender_idles || burst_left > 0) begin
			burst_left--;
		end else begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(negedge clk);
			burst_left = $urandom_range(0, burst_max);
		end
	endtask

	// stop offering, let every owed byte arrive, then change the pace
	task automatic settle(input bit idles, input int bmax, input int gmax, input rx_style_t style);
		cmd_valid <= 1'b0;
		@(posedge clk);
		wait (bytes_owed == 0);
		sender_idles = idles;
		burst_max    = bmax;
		gap_max      = gmax;
		burst_left   = $urandom_range(0, bmax);
		rx_style     = style;
		@(negedge clk);
	endtask

	// receiver back-pressure
	initial begin
		int tick;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req) begin
				bus_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				case (rx_style)
				RX_FREE:    bus_ready <= 1'b1;
				RX_COIN:    bus_ready <= ($urandom_range(0, 99) < 60);
				RX_PATTERN: bus_ready <= ((tick % 7) >= 3);
				default:    bus_ready <= ($urandom_range(0, 99) < 25);
				endcase
			end
		end
	end

	initial begin
		in_item_t it;
		int       drawn;
		int       target;
		int       r;
		bit       hold_done;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed: corners, wraps, unchanged pixels, unused mode
		settle(1'b0, 0, 1, RX_FREE);
		send_item(drawing(MODE_PIXEL, 0, 0, 0, 1'b1, 8'h00), 1'b0);
		send_item(drawing(MODE_PIXEL, 0, 0, 0, 1'b1, 8'h00), 1'b0);
		send_item(drawing(MODE_PIXEL, 5, 10, 0, 1'b0, 8'h00), 1'b0);
		send_item(drawing(MODE_PIXEL, 127, 63, 0, 1'b1, 8'h00), 1'b0);
		send_item(drawing(MODE_DATA, 0, 0, 0, 1'b0, 8'hFF), 1'b0);
		send_item(drawing(MODE_PIXEL, 127, 63, 0, 1'b0, 8'h00), 1'b0);
		send_item(drawing(MODE_POSITION, 127, 0, 7, 1'b0, 8'h00), 1'b0);
		send_item(drawing(MODE_DATA, 0, 0, 0, 1'b0, 8'hA5), 1'b0);
		send_item(drawing(MODE_DATA, 0, 0, 0, 1'b0, 8'h5A), 1'b0);
		send_item(drawing(MODE_DATA, 0, 0, 0, 1'b0, 8'h00), 1'b0);
		send_item(drawing(MODE_POSITION, 0, 0, 0, 1'b0, 8'h00), 1'b0);
		send_item(drawing(MODE_DATA, 0, 0, 0, 1'b0, 8'h81), 1'b0);
		send_item(drawing(MODE_PIXEL, 0, 7, 0, 1'b1, 8'h00), 1'b0);
		send_item(drawing(MODE_PIXEL, 0, 0, 0, 1'b0, 8'h00), 1'b0);
		send_item(drawing(MODE_UNUSED, 127, 63, 7, 1'b1, 8'hFF), 1'b0);
		send_item(drawing(MODE_POSITION, 64, 0, 3, 1'b0, 8'h00), 1'b0);
		send_item(drawing(MODE_DATA, 0, 0, 0, 1'b0, 8'h7E), 1'b0);
		send_item(drawing(MODE_PIXEL, 64, 31, 0, 1'b1, 8'h00), 1'b0);
		send_item(drawing(MODE_PIXEL, 85, 42, 0, 1'b1, 8'h00), 1'b0);
		send_item(drawing(MODE_PIXEL, 85, 42, 0, 1'b0, 8'h00), 1'b0);
		send_item(drawing(MODE_DATA, 0, 0, 0, 1'b0, 8'h01), 1'b0);

		drawn = 0;
		hold_done = 1'b0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: settle(1'b0, 0, 1, RX_FREE);
			1: settle(1'b1, 6, 5, RX_COIN);
			2: settle(1'b1, 12, 2, RX_PATTERN);
			default: settle(1'b1, 4, 8, RX_STARVED);
			endcase
			target = RANDOM_ITEMS * (ph + 1) / 4;
			while (drawn < target) begin
				it = drawing(MODE_DATA, $urandom_range(0, 127), $urandom_range(0, 63),
					$urandom_range(0, 7), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)));
				r = $urandom_range(0, 99);
				if (r < 4) begin
					it.mode = MODE_UNUSED;
				end else if (r < 50) begin
					it.mode = MODE_PIXEL;
					// small hot area at four corners so pixels get revisited
					if ($urandom_range(0, 99) < 60) begin
						it.column = ($urandom_range(0, 1) != 0) ? COL_W'($urandom_range(0, 3))
							: COL_W'($urandom_range(124, 127));
						it.pixel_row = ($urandom_range(0, 1) != 0) ? ROW_W'($urandom_range(0, 7))
							: ROW_W'($urandom_range(56, 63));
					end
				end else if (r < 65) begin
					it.mode = MODE_POSITION;
					if ($urandom_range(0, 99) < 30) it.column = COL_W'($urandom_range(124, 127));
				end
				send_item(it, ph == 2 && !hold_done && drawn >= target - 70);
				if (ph == 2 && drawn >= target - 70) hold_done = 1'b1;
				if (it.mode != MODE_UNUSED) drawn++;
			end
		end

		cmd_valid <= 1'b0;
		@(posedge clk);
		wait (bytes_owed == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && bytes_owed == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS * 1ns);
		$display("timeout, %0d bytes still owed", bytes_owed);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
